[src/kom_pkg.sv]
// ----------------------------------------------------------------------------
// kom_pkg
// Shared constants, codes and control types of the keyed ordered member list.
// ----------------------------------------------------------------------------
package kom_pkg;

	localparam int CAPACITY = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int STAT_W   = 3;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_LEADER = 2'd2,
		MODE_LOOKUP = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_DUP    = 3'd1,
		STAT_ABSENT = 3'd2,
		STAT_EMPTY  = 3'd3,
		STAT_FULL   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_DROP_HEAD,
		ACT_DROP_MID
	} act_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_HEAD,
		RD_TGT
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_INSERT,
		S_HEAD_RD,
		S_HEAD_WR,
		S_LINK_RD,
		S_LINK_WR,
		S_LEAD_RD,
		S_LEAD_WAIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    decide;
		logic    insert;
		logic    drop_head;
		logic    drop_link;
		logic    out_load;
		rd_sel_t rd_sel;
	} kom_cmd_t;

	typedef struct packed {
		logic scan_done;
		act_t act;
		logic out_free;
	} kom_sts_t;

endpackage

[src/kom_ctrl.sv]
// ----------------------------------------------------------------------------
// kom_ctrl
// Sequencer for one item: key scan, decision, link update, leader read.
// ----------------------------------------------------------------------------
module kom_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kom_pkg::kom_sts_t sts,
	output kom_pkg::kom_cmd_t cmd
);
	import kom_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.rd_sel = RD_SCAN;
				if (sts.scan_done) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				case (sts.act)
					ACT_INSERT:    state_nxt = S_INSERT;
					ACT_DROP_HEAD: state_nxt = S_HEAD_RD;
					ACT_DROP_MID:  state_nxt = S_LINK_RD;
					default:       state_nxt = S_LEAD_RD;
				endcase
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_nxt  = S_LEAD_RD;
			end
			S_HEAD_RD: begin
				cmd.rd_sel = RD_HEAD;
				state_nxt  = S_HEAD_WR;
			end
			S_HEAD_WR: begin
				cmd.rd_sel    = RD_HEAD;
				cmd.drop_head = 1'b1;
				state_nxt     = S_LEAD_RD;
			end
			S_LINK_RD: begin
				cmd.rd_sel = RD_TGT;
				state_nxt  = S_LINK_WR;
			end
			S_LINK_WR: begin
				cmd.rd_sel    = RD_TGT;
				cmd.drop_link = 1'b1;
				state_nxt     = S_LEAD_RD;
			end
			S_LEAD_RD: begin
				cmd.rd_sel = RD_HEAD;
				state_nxt  = S_LEAD_WAIT;
			end
			S_LEAD_WAIT: begin
				cmd.rd_sel = RD_HEAD;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

[src/kom_dp.sv]
// ----------------------------------------------------------------------------
// kom_dp
// Slot store, link memories, head/tail/count registers and result register.
// ----------------------------------------------------------------------------
module kom_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kom_pkg::kom_cmd_t          cmd,
	output kom_pkg::kom_sts_t          sts,
	input  logic [1:0]                 mode,
	input  logic [kom_pkg::KEY_W-1:0]  member_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kom_pkg::STAT_W-1:0] status,
	output logic                       leader_valid,
	output logic [kom_pkg::KEY_W-1:0]  leader_id,
	output logic [kom_pkg::CNT_W-1:0]  group_size
);
	import kom_pkg::*;

	function automatic logic [SLOT_W-1:0] first_free(input logic [CAPACITY-1:0] used);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	mode_t               mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [CAPACITY-1:0] used_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic                found_q;
	logic [SLOT_W-1:0]   tgt_q;
	status_t             status_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                cmp_v_s1;
	logic [SLOT_W-1:0]   cmp_idx_s1;
	logic                out_valid_q;

	logic [STAT_W-1:0]   res_status_q;
	logic                res_lvalid_q;
	logic [KEY_W-1:0]    res_lid_q;
	logic [CNT_W-1:0]    res_size_q;

	logic [KEY_W-1:0]    key_mem [CAPACITY];
	logic [SLOT_W-1:0]   next_mem [CAPACITY];
	logic [SLOT_W-1:0]   prev_mem [CAPACITY];
	logic [KEY_W-1:0]    key_rd_q;
	logic [SLOT_W-1:0]   next_rd_q;
	logic [SLOT_W-1:0]   prev_rd_q;

	logic [SLOT_W-1:0]   rd_addr;
	logic [SLOT_W-1:0]   free_slot;
	logic                hit;
	logic                scan_more;
	logic                empty;
	status_t             dec_status;
	act_t                dec_act;

	logic                next_we;
	logic [SLOT_W-1:0]   next_wa;
	logic [SLOT_W-1:0]   next_wd;
	logic                prev_we;
	logic [SLOT_W-1:0]   prev_wa;
	logic [SLOT_W-1:0]   prev_wd;

	assign free_slot = first_free(used_q);
	assign empty     = (count_q == '0);
	assign scan_more = (cnt_q < CNT_W'(CAPACITY));
	// The read data lines up with the index issued in the previous cycle.
	assign hit = cmp_v_s1 && used_q[cmp_idx_s1] && (key_rd_q == key_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_SCAN: rd_addr = cnt_q[SLOT_W-1:0];
			RD_HEAD: rd_addr = head_q;
			RD_TGT:  rd_addr = tgt_q;
			default: rd_addr = head_q;
		endcase
	end

	always_comb begin
		dec_status = STAT_OK;
		dec_act    = ACT_NONE;
		case (mode_q)
			MODE_INSERT: begin
				if (found_q) begin
					dec_status = STAT_DUP;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					dec_status = STAT_FULL;
				end else begin
					dec_act = ACT_INSERT;
				end
			end
			MODE_REMOVE: begin
				if (!found_q) begin
					dec_status = STAT_ABSENT;
				end else if (tgt_q == head_q) begin
					dec_act = ACT_DROP_HEAD;
				end else begin
					dec_act = ACT_DROP_MID;
				end
			end
			MODE_LEADER: begin
				if (empty) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_act = ACT_DROP_HEAD;
				end
			end
			MODE_LOOKUP: begin
				if (!found_q) begin
					dec_status = STAT_ABSENT;
				end
			end
			default: begin
				dec_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		next_we = cmd.insert && !empty;
		next_wa = tail_q;
		next_wd = free_slot;
		prev_we = cmd.insert;
		prev_wa = free_slot;
		prev_wd = empty ? '0 : tail_q;
		// Unlinking a middle entry joins its neighbors to each other.
		if (cmd.drop_link && (tgt_q != tail_q)) begin
			next_we = 1'b1;
			next_wa = prev_rd_q;
			next_wd = next_rd_q;
			prev_we = 1'b1;
			prev_wa = next_rd_q;
			prev_wd = prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_mem[free_slot] <= key_q;
		end
		key_rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			key_q  <= member_id;
		end
		if (cmd.out_load) begin
			res_status_q <= status_q;
			res_lvalid_q <= !empty;
			res_lid_q    <= empty ? '0 : key_rd_q;
			res_size_q   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			tgt_q       <= '0;
			status_q    <= STAT_OK;
			cnt_q       <= '0;
			cmp_v_s1    <= 1'b0;
			cmp_idx_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q  <= 1'b0;
				cnt_q    <= '0;
				cmp_v_s1 <= 1'b0;
			end
			if (cmd.scan) begin
				if (scan_more) begin
					cnt_q <= cnt_q + 1'b1;
				end
				cmp_v_s1   <= scan_more;
				cmp_idx_s1 <= cnt_q[SLOT_W-1:0];
				if (hit && !found_q) begin
					found_q <= 1'b1;
					tgt_q   <= cmp_idx_s1;
				end
			end
			if (cmd.decide) begin
				status_q <= dec_status;
			end
			if (cmd.insert) begin
				used_q[free_slot] <= 1'b1;
				tail_q            <= free_slot;
				if (empty) begin
					head_q <= free_slot;
				end
				count_q <= count_q + 1'b1;
			end
			if (cmd.drop_head) begin
				used_q[head_q] <= 1'b0;
				if (count_q <= CNT_W'(1)) begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
				end else begin
					head_q  <= next_rd_q;
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.drop_link) begin
				used_q[tgt_q] <= 1'b0;
				if (tgt_q == tail_q) begin
					tail_q <= prev_rd_q;
				end
				count_q <= count_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.scan_done = !scan_more && !cmp_v_s1;
	assign sts.act       = dec_act;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = res_status_q;
	assign leader_valid = res_lvalid_q;
	assign leader_id    = res_lid_q;
	assign group_size   = res_size_q;

endmodule

[src/keyed_ordered_member_list_top.sv]
// ----------------------------------------------------------------------------
// keyed_ordered_member_list_top
// Arrival-ordered member set with insert, remove by id, remove leader, lookup.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat contents
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | mode, member_id
//  out     | out_valid/ out_ready | status, leader_valid, leader_id, group_size
//
// After a beat is accepted, the sequencer runs a pipelined scan of all 16
// slots, a decision state, any link update (an insert write, or a read then a
// write to unlink) and the leader key read; it then takes the next beat.
// Reset clears the slot valid bits, head, tail and count; no clearing pass.
// A pending result sits in the output register, so a new beat is taken while
// it waits; the sequencer stalls only when a second result is ready to load.
// ----------------------------------------------------------------------------
module keyed_ordered_member_list_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [kom_pkg::KEY_W-1:0]  member_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kom_pkg::STAT_W-1:0] status,
	output logic                       leader_valid,
	output logic [kom_pkg::KEY_W-1:0]  leader_id,
	output logic [kom_pkg::CNT_W-1:0]  group_size
);
	import kom_pkg::*;

	kom_cmd_t cmd;
	kom_sts_t sts;

	kom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kom_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.member_id    (member_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.leader_valid (leader_valid),
		.leader_id    (leader_id),
		.group_size   (group_size)
	);

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed ordered member list. A short table of
// directed beats walks the empty, duplicate, last-member, full and unlink
// cases, then about a thousand random beats alternate between filling and
// draining the group. Results are checked against typed rows or a bench model.
// ----------------------------------------------------------------------------
module tb_top;
	import kom_pkg::*;

	localparam int NUM_DIR      = 26;
	localparam int RAND_BEATS   = 1030;
	localparam int CALM_BEATS   = 150;
	localparam int POOL_N       = 24;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		status_t            st;
		logic               lead_ok;
		logic [KEY_W-1:0]   lead_id;
		logic [CNT_W-1:0]   size;
	} answer_t;

	typedef struct packed {
		mode_t              op;
		logic [KEY_W-1:0]   id;
		logic               typed;
		answer_t            ans;
	} dir_row_t;

	localparam answer_t NO_ANS = '{STAT_OK, 1'b0, 16'h0000, 5'd0};

	// Directed beats; rows with typed set carry their own expected answer.
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{MODE_LOOKUP, 16'h0000, 1'b1, '{STAT_ABSENT, 1'b0, 16'h0000, 5'd0}},
		'{MODE_LEADER, 16'h5A5A, 1'b1, '{STAT_EMPTY,  1'b0, 16'h0000, 5'd0}},
		'{MODE_INSERT, 16'h0000, 1'b1, '{STAT_OK,     1'b1, 16'h0000, 5'd1}},
		'{MODE_REMOVE, 16'h0000, 1'b1, '{STAT_OK,     1'b0, 16'h0000, 5'd0}},
		'{MODE_INSERT, 16'hFFFF, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd1}},
		'{MODE_INSERT, 16'hFFFF, 1'b1, '{STAT_DUP,    1'b1, 16'hFFFF, 5'd1}},
		'{MODE_INSERT, 16'h0001, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd2}},
		'{MODE_INSERT, 16'h0002, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd3}},
		'{MODE_INSERT, 16'h0004, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd4}},
		'{MODE_INSERT, 16'h0008, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd5}},
		'{MODE_INSERT, 16'h0010, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd6}},
		'{MODE_INSERT, 16'h0020, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd7}},
		'{MODE_INSERT, 16'h0040, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd8}},
		'{MODE_INSERT, 16'h0080, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd9}},
		'{MODE_INSERT, 16'h0100, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd10}},
		'{MODE_INSERT, 16'h0200, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd11}},
		'{MODE_INSERT, 16'h0400, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd12}},
		'{MODE_INSERT, 16'h0800, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd13}},
		'{MODE_INSERT, 16'h1000, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd14}},
		'{MODE_INSERT, 16'h2000, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd15}},
		'{MODE_INSERT, 16'h4000, 1'b1, '{STAT_OK,     1'b1, 16'hFFFF, 5'd16}},
		'{MODE_INSERT, 16'h1234, 1'b1, '{STAT_FULL,   1'b1, 16'hFFFF, 5'd16}},
		'{MODE_REMOVE, 16'h0080, 1'b0, NO_ANS},
		'{MODE_REMOVE, 16'h4000, 1'b0, NO_ANS},
		'{MODE_REMOVE, 16'hFFFF, 1'b0, NO_ANS},
		'{MODE_LOOKUP, 16'h0100, 1'b0, NO_ANS}
	};

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [1:0]         mode         = 2'b00;
	logic [KEY_W-1:0]   member_id    = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [STAT_W-1:0]  status;
	logic               leader_valid;
	logic [KEY_W-1:0]   leader_id;
	logic [CNT_W-1:0]   group_size;

	// Model of the member list.
	bit                 occ  [CAPACITY];
	logic [KEY_W-1:0]   keys [CAPACITY];
	logic [SLOT_W-1:0]  nxt  [CAPACITY];
	logic [SLOT_W-1:0]  prv  [CAPACITY];
	logic [SLOT_W-1:0]  head_s  = '0;
	logic [SLOT_W-1:0]  tail_s  = '0;
	int                 members = 0;

	answer_t            pending_answers [$];
	logic [KEY_W-1:0]   id_pool [POOL_N];
	int                 err_cnt     = 0;
	int                 idle_cycles = 0;
	int                 stall_left  = 0;
	bit                 calm        = 1'b0;

	keyed_ordered_member_list_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.member_id    (member_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.leader_valid (leader_valid),
		.leader_id    (leader_id),
		.group_size   (group_size)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int slot_of(input logic [KEY_W-1:0] id);
		for (int s = 0; s < CAPACITY; s++)
			if (occ[s] && keys[s] == id)
				return s;
		return CAPACITY;
	endfunction

	task automatic drop_leader();
		occ[head_s] = 1'b0;
		if (members <= 1) begin
			head_s  = '0;
			tail_s  = '0;
			members = 0;
		end else begin
			head_s = nxt[head_s];
			members--;
		end
	endtask

	task automatic apply_member_cmd(input mode_t op, input logic [KEY_W-1:0] id,
			output answer_t ans);
		int      s;
		int      f;
		status_t st;
		st = STAT_OK;
		s  = slot_of(id);
		case (op)
			MODE_INSERT: begin
				if (s < CAPACITY)
					st = STAT_DUP;
				else if (members >= CAPACITY)
					st = STAT_FULL;
				else begin
					// New members take the lowest free slot.
					f = 0;
					while (occ[f])
						f++;
					occ[f]  = 1'b1;
					keys[f] = id;
					nxt[f]  = '0;
					if (members == 0) begin
						prv[f] = '0;
						head_s = SLOT_W'(f);
					end else begin
						prv[f]      = tail_s;
						nxt[tail_s] = SLOT_W'(f);
					end
					tail_s = SLOT_W'(f);
					members++;
				end
			end
			MODE_REMOVE: begin
				if (s >= CAPACITY)
					st = STAT_ABSENT;
				else if (s == int'(head_s))
					drop_leader();
				else begin
					occ[s] = 1'b0;
					if (s == int'(tail_s))
						tail_s = prv[s];
					else begin
						nxt[prv[s]] = nxt[s];
						prv[nxt[s]] = prv[s];
					end
					members--;
				end
			end
			MODE_LEADER: begin
				if (members == 0)
					st = STAT_EMPTY;
				else
					drop_leader();
			end
			default: begin
				if (s >= CAPACITY)
					st = STAT_ABSENT;
			end
		endcase
		ans.st      = st;
		ans.lead_ok = (members > 0);
		ans.lead_id = (members > 0) ? keys[head_s] : '0;
		ans.size    = CNT_W'(members);
	endtask

	// Leaves in_valid high on return; the caller either sends the next beat
	// in the same step or lowers it.
	task automatic send_beat(input mode_t op, input logic [KEY_W-1:0] id,
			input logic typed, input answer_t typed_ans);
		answer_t ans;
		in_valid  <= 1'b1;
		mode      <= op;
		member_id <= id;
		do
			@(posedge clk);
		while (!in_ready);
		apply_member_cmd(op, id, ans);
		pending_answers.push_back(typed ? typed_ans : ans);
	endtask

	task automatic sender_gap();
		int n;
		if (!calm && $urandom_range(3) == 0) begin
			n = $urandom_range(10, 1);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_beat(input bit filling);
		int                pick;
		int                steps;
		logic [SLOT_W-1:0] at;
		mode_t             op;
		logic [KEY_W-1:0]  id;
		pick = $urandom_range(99);
		if (pick < (filling ? 55 : 20))
			op = MODE_INSERT;
		else if (pick < (filling ? 75 : 65))
			op = MODE_REMOVE;
		else if (pick < 85)
			op = MODE_LEADER;
		else
			op = MODE_LOOKUP;
		id   = id_pool[$urandom_range(POOL_N - 1)];
		pick = $urandom_range(99);
		if (pick < 15)
			id = KEY_W'($urandom_range(16'hFFFF));
		else if (members > 0 && pick < (op == MODE_INSERT ? 30 : 75)) begin
			// Pick a current member anywhere in the chain: head, middle or tail.
			at    = head_s;
			steps = $urandom_range(members - 1);
			repeat (steps)
				at = nxt[at];
			id = keys[at];
		end
		send_beat(op, id, 1'b0, NO_ANS);
	endtask

	initial begin
		for (int s = 0; s < CAPACITY; s++) begin
			occ[s]  = 1'b0;
			keys[s] = '0;
			nxt[s]  = '0;
			prv[s]  = '0;
		end
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int k = 2; k < POOL_N; k++)
			id_pool[k] = KEY_W'($urandom_range(16'hFFFF));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			send_beat(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].typed, DIR_ROWS[i].ans);
			sender_gap();
		end
		wait_results_drained();

		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i == RAND_BEATS / 2)
				wait_results_drained();
			calm = (i >= RAND_BEATS - CALM_BEATS);
			random_beat(((i / 90) % 2) == 0);
			sender_gap();
		end
		in_valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_answers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver back-pressure: random bursts of stall on out_ready.
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(7) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(9);
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result beat: status %0d leader %0b/%h size %0d",
						status, leader_valid, leader_id, group_size);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st || leader_valid !== want.lead_ok ||
						leader_id !== want.lead_id || group_size !== want.size) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: expected st %0d lv %0b id %h size %0d, got st %0d lv %0b id %h size %0d",
							want.st, want.lead_ok, want.lead_id, want.size,
							status, leader_valid, leader_id, group_size);
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

[keyed_ordered_member_list_top.f]
src/kom_pkg.sv
src/kom_ctrl.sv
src/kom_dp.sv
src/keyed_ordered_member_list_top.sv
dv/tb_top.sv
